>>> hw/rtl/vtie_pkg.sv
// Package for the VAX to IEEE element converter.
// Element kind codes, byte-order mode codes, register indexes and the config bundle.
// No dependencies.
package vtie_pkg;

  // Element kinds carried in tuser
  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_LOGICAL = 3'd1,
    KIND_WORD    = 3'd2,
    KIND_INT     = 3'd3,
    KIND_REAL    = 3'd4,
    KIND_DOUBLE  = 3'd5,
    KIND_CHAR    = 3'd6
  } kind_e;

  // Float byte-order modes; code 3 behaves as IEEE
  localparam logic [1:0] MODE_VAX = 2'd0;
  localparam logic [1:0] MODE_REV = 2'd2;

  // Register indexes on the config port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_IN_BAD_INT     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OUT_BAD_INT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IN_BAD_REAL    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OUT_BAD_REAL   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IN_BAD_DOUBLE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_BAD_DOUBLE = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ORDER_MODES    = 3'd6;

  // Exponent adjustments: F bias 128 to 127 with hidden-bit shift, D bias to 1023
  localparam logic [7:0]  F_EXP_ADJ = 8'd2;
  localparam logic [10:0] D_EXP_ADJ = 11'd894;

  // Configuration bundle handed to the converter
  typedef struct packed {
    logic [55:0] in_bad_int;
    logic [55:0] out_bad_int;
    logic [31:0] in_bad_real;
    logic [31:0] out_bad_real;
    logic [63:0] in_bad_double;
    logic [63:0] out_bad_double;
    logic        swap_word;
    logic        swap_int;
    logic [1:0]  real_mode;
    logic [1:0]  double_mode;
  } cfg_t;

endpackage

>>> hw/rtl/vtie_cfg_regs.sv
// Configuration register file of the VAX to IEEE element converter.
// Depends on vtie_pkg for register indexes and the cfg_t bundle.
module vtie_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [vtie_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [63:0]                   wdata_i,
  output vtie_pkg::cfg_t                cfg_o
);
  import vtie_pkg::*;

  cfg_t cfg_q;

  // Write one register per enabled cycle, dropping bits above its width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (we_i) begin
      unique case (idx_i)
        REG_IN_BAD_INT:     cfg_q.in_bad_int     <= wdata_i[55:0];
        REG_OUT_BAD_INT:    cfg_q.out_bad_int    <= wdata_i[55:0];
        REG_IN_BAD_REAL:    cfg_q.in_bad_real    <= wdata_i[31:0];
        REG_OUT_BAD_REAL:   cfg_q.out_bad_real   <= wdata_i[31:0];
        REG_IN_BAD_DOUBLE:  cfg_q.in_bad_double  <= wdata_i;
        REG_OUT_BAD_DOUBLE: cfg_q.out_bad_double <= wdata_i;
        REG_ORDER_MODES: begin
          cfg_q.swap_word   <= wdata_i[0];
          cfg_q.swap_int    <= wdata_i[1];
          cfg_q.real_mode   <= wdata_i[3:2];
          cfg_q.double_mode <= wdata_i[5:4];
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/vtie_convert.sv
// Element conversion logic: bad-pattern replacement, swaps, VAX F/D to IEEE.
// Purely combinational; depends on vtie_pkg.
module vtie_convert (
  input  logic [2:0]     kind_i,
  input  logic [63:0]    data_i,
  input  vtie_pkg::cfg_t cfg_i,
  output logic [63:0]    result_o,
  output logic           was_bad_o
);
  import vtie_pkg::*;

  kind_e       kind;
  logic [7:0]  b [8];
  logic [7:0]  ef, ef_adj;
  logic [23:0] f_den;
  logic [7:0]  tr [4];
  logic [31:0] real_ieee;
  logic [10:0] ed;
  logic [7:0]  td [8];
  logic [63:0] dbl_ieee;
  logic [31:0] real_vax;

  assign kind = kind_e'(kind_i);

  // Split the element into VAX byte lanes
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = data_i[8*i +: 8];
    end
  end

  assign real_vax = data_i[31:0];

  // VAX F to IEEE single, big-endian bytes tr[0..3]
  always_comb begin
    ef     = {b[1][6:0], b[0][7]};
    ef_adj = ef - F_EXP_ADJ;
    f_den  = {1'b1, b[0][6:0], b[3], b[2]};
    if (ef == 8'd1) begin
      f_den = f_den >> 2;
    end else begin
      f_den = f_den >> 1;
    end
    if (ef > F_EXP_ADJ) begin
      tr[0] = {b[1][7], ef_adj[7:1]};
      tr[1] = {ef_adj[0], b[0][6:0]};
      tr[2] = b[3];
      tr[3] = b[2];
    end else if (ef == 8'd0) begin
      // Reserved operand and zero both give zero
      tr[0] = 8'd0;
      tr[1] = 8'd0;
      tr[2] = 8'd0;
      tr[3] = 8'd0;
    end else begin
      // Exponents one and two land in the IEEE denormal range
      tr[0] = {b[1][7], 7'd0};
      tr[1] = {1'b0, f_den[22:16]};
      tr[2] = f_den[15:8];
      tr[3] = f_den[7:0];
    end
    for (int i = 0; i < 4; i++) begin
      if (cfg_i.real_mode == MODE_REV) begin
        real_ieee[8*(3-i) +: 8] = tr[i];
      end else begin
        real_ieee[8*i +: 8] = tr[i];
      end
    end
  end

  // VAX D to IEEE double, low three fraction bits truncated
  always_comb begin
    ed = {3'd0, b[1][6:0], b[0][7]} + D_EXP_ADJ;
    if (ef == 8'd0) begin
      for (int i = 0; i < 8; i++) begin
        td[i] = 8'd0;
      end
    end else begin
      td[0] = {b[1][7], ed[10:4]};
      td[1] = {ed[3:0], b[0][6:3]};
      td[2] = {b[0][2:0], b[3][7:3]};
      td[3] = {b[3][2:0], b[2][7:3]};
      td[4] = {b[2][2:0], b[5][7:3]};
      td[5] = {b[5][2:0], b[4][7:3]};
      td[6] = {b[4][2:0], b[7][7:3]};
      td[7] = {b[7][2:0], b[6][7:3]};
    end
    for (int i = 0; i < 8; i++) begin
      if (cfg_i.double_mode == MODE_REV) begin
        dbl_ieee[8*(7-i) +: 8] = td[i];
      end else begin
        dbl_ieee[8*i +: 8] = td[i];
      end
    end
  end

  // Select by kind, replacing bad patterns first
  always_comb begin
    result_o  = data_i;
    was_bad_o = 1'b0;
    unique case (kind)
      KIND_BYTE: begin
        if (b[0] == cfg_i.in_bad_int[7:0]) begin
          result_o  = {56'd0, cfg_i.out_bad_int[7:0]};
          was_bad_o = 1'b1;
        end else begin
          result_o = {56'd0, b[0]};
        end
      end
      KIND_LOGICAL: result_o = {63'd0, data_i[0]};
      KIND_WORD: begin
        if (data_i[15:0] == cfg_i.in_bad_int[23:8]) begin
          result_o  = {48'd0, cfg_i.out_bad_int[23:8]};
          was_bad_o = 1'b1;
        end else if (cfg_i.swap_word) begin
          result_o = {48'd0, b[0], b[1]};
        end else begin
          result_o = {48'd0, data_i[15:0]};
        end
      end
      KIND_INT: begin
        if (real_vax == cfg_i.in_bad_int[55:24]) begin
          result_o  = {32'd0, cfg_i.out_bad_int[55:24]};
          was_bad_o = 1'b1;
        end else if (cfg_i.swap_int) begin
          result_o = {32'd0, b[0], b[1], b[2], b[3]};
        end else begin
          result_o = {32'd0, real_vax};
        end
      end
      KIND_REAL: begin
        if (real_vax == cfg_i.in_bad_real) begin
          result_o  = {32'd0, cfg_i.out_bad_real};
          was_bad_o = 1'b1;
        end else if (cfg_i.real_mode == MODE_VAX) begin
          result_o = {32'd0, real_vax};
        end else begin
          result_o = {32'd0, real_ieee};
        end
      end
      KIND_DOUBLE: begin
        if (data_i == cfg_i.in_bad_double) begin
          result_o  = cfg_i.out_bad_double;
          was_bad_o = 1'b1;
        end else if (cfg_i.double_mode == MODE_VAX) begin
          result_o = data_i;
        end else begin
          result_o = dbl_ieee;
        end
      end
      // Char and unused codes pass through
      default: result_o = data_i;
    endcase
  end

endmodule

>>> hw/rtl/vax_to_ieee_element_converter_top.sv
// Two register stages; an accepted word passes from the input register through the conversion
// logic into the result register. Throughput: one word per cycle while the output is not stalled.
// Backpressure stalls the result register; an empty input register still fills while
// the result waits, and the input is refused only with both registers full.
// Reset: asynchronous, active low; clears both valid flags and all config registers.
// Depends on vtie_pkg, vtie_cfg_regs and vtie_convert.
module vax_to_ieee_element_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] data
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  input  logic        s_axis_tlast,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] result
  output logic        m_axis_tuser,   // [0] was_bad
  output logic        m_axis_tlast,
  // Config write port
  input  logic        cfg_we_i,
  input  logic [vtie_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import vtie_pkg::*;

  cfg_t        cfg;
  logic        in_vld_q;
  logic [2:0]  kind_q;
  logic [63:0] data_q;
  logic        last_in_q;
  logic        out_vld_q;
  logic [63:0] result_q;
  logic        was_bad_q;
  logic        last_out_q;
  logic [63:0] conv_result;
  logic        conv_bad;
  logic        out_adv;
  logic        in_adv;

  vtie_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  vtie_convert u_conv (
    .kind_i    (kind_q),
    .data_i    (data_q),
    .cfg_i     (cfg),
    .result_o  (conv_result),
    .was_bad_o (conv_bad)
  );

  // Result register loads when empty or when its word is taken
  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      kind_q    <= s_axis_tuser;
      data_q    <= s_axis_tdata;
      last_in_q <= s_axis_tlast;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      result_q   <= conv_result;
      was_bad_q  <= conv_bad;
      last_out_q <= last_in_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = result_q;
  assign m_axis_tuser  = was_bad_q;
  assign m_axis_tlast  = last_out_q;

  // A full input register moving on always produces a result word
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_adv) |=> m_axis_tvalid)
    else $error("input word lost on advance");

  // Input is refused only with both registers occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q))
    else $error("input stalled with a free register");

  // Logical and pass-through kinds never report a replaced pattern
  a_bad_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && conv_bad) |-> (kind_q != KIND_LOGICAL && kind_q <= KIND_DOUBLE))
    else $error("bad flag on a kind without bad pattern");

  // A stalled result word holds its data and its was_bad flag
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(result_q) && $stable(was_bad_q)))
    else $error("result changed while stalled");

endmodule

>>> tb/sv/vtie_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the VAX to IEEE element converter testbench.
// Holds a register copy, predicts each converted word and checks results in order.
// Depends on vtie_pkg for kind codes, mode codes, register indexes and cfg_t.
package vtie_tb_pkg;
  import vtie_pkg::*;

  // One converted element as it should leave the block
  typedef struct packed {
    logic [63:0] result;
    logic        was_bad;
    logic        last;
  } conv_word_t;

  class conv_scoreboard;
    cfg_t        cfg;
    conv_word_t  expected_words[$];
    int unsigned checked;
    int unsigned mismatches;
    int unsigned bad_expected;

    function new();
      cfg          = '0;
      checked      = 0;
      mismatches   = 0;
      bad_expected = 0;
    endfunction

    // Mirror a register write, trimmed to the register width
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
      case (idx)
        REG_IN_BAD_INT:     cfg.in_bad_int     = value[55:0];
        REG_OUT_BAD_INT:    cfg.out_bad_int    = value[55:0];
        REG_IN_BAD_REAL:    cfg.in_bad_real    = value[31:0];
        REG_OUT_BAD_REAL:   cfg.out_bad_real   = value[31:0];
        REG_IN_BAD_DOUBLE:  cfg.in_bad_double  = value;
        REG_OUT_BAD_DOUBLE: cfg.out_bad_double = value;
        REG_ORDER_MODES: begin
          {cfg.double_mode, cfg.real_mode, cfg.swap_int, cfg.swap_word} = value[5:0];
        end
        default: ;
      endcase
    endfunction

    // Work out the converted word for one element
    function conv_word_t convert_element(logic [2:0] kind, logic [63:0] data, logic last);
      conv_word_t  w;
      logic [7:0]  b [8];
      logic [7:0]  t [8];
      logic [7:0]  ex;
      logic [10:0] dex;
      logic [23:0] frac;
      logic [1:0]  mode;
      int          i;
      w.result  = data;
      w.was_bad = 1'b0;
      w.last    = last;
      for (i = 0; i < 8; i++) begin
        b[i] = data[8*i +: 8];
        t[i] = '0;
      end
      case (kind)
        KIND_BYTE: begin
          w.result = {56'h0, b[0]};
          if (b[0] == cfg.in_bad_int[7:0]) begin
            w.result  = {56'h0, cfg.out_bad_int[7:0]};
            w.was_bad = 1'b1;
          end
        end
        KIND_LOGICAL: w.result = {63'h0, data[0]};
        KIND_WORD: begin
          if (data[15:0] == cfg.in_bad_int[23:8]) begin
            w.result  = {48'h0, cfg.out_bad_int[23:8]};
            w.was_bad = 1'b1;
          end else if (cfg.swap_word) begin
            w.result = {48'h0, b[0], b[1]};
          end else begin
            w.result = {48'h0, data[15:0]};
          end
        end
        KIND_INT: begin
          if (data[31:0] == cfg.in_bad_int[55:24]) begin
            w.result  = {32'h0, cfg.out_bad_int[55:24]};
            w.was_bad = 1'b1;
          end else if (cfg.swap_int) begin
            w.result = {32'h0, b[0], b[1], b[2], b[3]};
          end else begin
            w.result = {32'h0, data[31:0]};
          end
        end
        KIND_REAL: begin
          mode = cfg.real_mode;
          if (data[31:0] == cfg.in_bad_real) begin
            w.result  = {32'h0, cfg.out_bad_real};
            w.was_bad = 1'b1;
          end else if (mode == MODE_VAX) begin
            w.result = {32'h0, data[31:0]};
          end else begin
            ex = {b[1][6:0], b[0][7]};
            if (ex > F_EXP_ADJ) begin
              // normal number: rebias and move the fraction halves
              ex   = ex - F_EXP_ADJ;
              t[0] = {b[1][7], ex[7:1]};
              t[1] = {ex[0], b[0][6:0]};
              t[2] = b[3];
              t[3] = b[2];
            end else if (ex != 8'h0) begin
              // smallest exponents land in the IEEE denormal range
              frac = {1'b1, b[0][6:0], b[3], b[2]};
              frac = frac >> (3 - ex);
              t[0] = {b[1][7], 7'h0};
              t[1] = {1'b0, frac[22:16]};
              t[2] = frac[15:8];
              t[3] = frac[7:0];
            end
            w.result = '0;
            for (i = 0; i < 4; i++) begin
              w.result[8*((mode == MODE_REV) ? 3 - i : i) +: 8] = t[i];
            end
          end
        end
        KIND_DOUBLE: begin
          mode = cfg.double_mode;
          if (data == cfg.in_bad_double) begin
            w.result  = cfg.out_bad_double;
            w.was_bad = 1'b1;
          end else if (mode != MODE_VAX) begin
            ex = {b[1][6:0], b[0][7]};
            if (ex != 8'h0) begin
              // widen the exponent and shift the fraction down by three bits
              dex  = {3'b0, ex} + D_EXP_ADJ;
              t[0] = {b[1][7], dex[10:4]};
              t[1] = {dex[3:0], b[0][6:3]};
              t[2] = {b[0][2:0], b[3][7:3]};
              t[3] = {b[3][2:0], b[2][7:3]};
              t[4] = {b[2][2:0], b[5][7:3]};
              t[5] = {b[5][2:0], b[4][7:3]};
              t[6] = {b[4][2:0], b[7][7:3]};
              t[7] = {b[7][2:0], b[6][7:3]};
            end
            w.result = '0;
            for (i = 0; i < 8; i++) begin
              w.result[8*((mode == MODE_REV) ? 7 - i : i) +: 8] = t[i];
            end
          end
        end
        default: w.result = data;
      endcase
      return w;
    endfunction

    // Queue the prediction for an accepted element
    function void note_input(logic [2:0] kind, logic [63:0] data, logic last);
      conv_word_t w;
      w = convert_element(kind, data, last);
      if (w.was_bad) bad_expected++;
      expected_words.push_back(w);
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: mismatch at result %0d: %s", $time, checked, msg);
    endfunction

    // Compare an accepted result against the oldest prediction
    function void check_result(logic [63:0] result, logic was_bad, logic last);
      conv_word_t want;
      checked++;
      if (expected_words.size() == 0) begin
        flag($sformatf("result %h arrived with nothing outstanding", result));
        return;
      end
      want = expected_words.pop_front();
      if (result !== want.result) begin
        flag($sformatf("data expected %h, got %h", want.result, result));
      end
      if (was_bad !== want.was_bad) begin
        flag($sformatf("was_bad expected %b, got %b", want.was_bad, was_bad));
      end
      if (last !== want.last) begin
        flag($sformatf("tlast expected %b, got %b", want.last, last));
      end
    endfunction
  endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench for vax_to_ieee_element_converter_top.
// Drives elements and register writes, checks every converted word in the scoreboard.
// Depends on vtie_pkg and vtie_tb_pkg.
module testbench;
  import vtie_pkg::*;
  import vtie_tb_pkg::*;

  localparam logic [2:0] KIND_UNKNOWN = 3'd7;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned PhaseWords = 95;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata;   // [63:0] data
  logic [2:0]         s_axis_tuser;   // [2:0] kind
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [63:0]        m_axis_tdata;   // [63:0] result
  logic               m_axis_tuser;   // [0] was_bad
  logic               m_axis_tlast;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [63:0]        cfg_wdata_i;

  conv_scoreboard sb;
  bit             tx_idle = 1'b1;
  bit             rx_idle = 1'b1;
  int             hold_left = 0;
  event           hold_ev;
  int unsigned    words_sent = 0;
  int unsigned    settings_used = 0;

  vax_to_ieee_element_converter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 100 MHz clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count down the long receiver hold-off once it is requested
  initial begin
    forever begin
      @(hold_ev);
      hold_left = 300;
      while (hold_left > 0) begin
        @(posedge clk_i);
        hold_left--;
      end
    end
  end

  // Offer one word, after a random gap while tx_idle is set, and return once it is accepted
  task automatic send_word(input logic [2:0] kind, input logic [63:0] data, input logic last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(kind, data, last);
    words_sent++;
  endtask

  // Draw an element: mostly clean words, with bad-pattern hits, edge exponents and garbage
  task automatic send_random_word();
    logic [2:0]  kind;
    logic [63:0] data;
    int unsigned sel;
    logic [7:0]  edge_exps [5] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'hff};
    kind = 3'($urandom_range(0, 7));
    data = {$urandom, $urandom};
    sel  = $urandom_range(0, 7);
    if (sel == 1 || sel == 2) data[14:7] = edge_exps[$urandom_range(0, 4)];
    if (sel == 0) begin
      case (kind)
        KIND_BYTE:   data[7:0]  = sb.cfg.in_bad_int[7:0];
        KIND_WORD:   data[15:0] = sb.cfg.in_bad_int[23:8];
        KIND_INT:    data[31:0] = sb.cfg.in_bad_int[55:24];
        KIND_REAL:   data[31:0] = sb.cfg.in_bad_real;
        KIND_DOUBLE: data       = sb.cfg.in_bad_double;
        default: ;
      endcase
    end
    // clear bytes above the element width on well-formed words
    if (sel >= 2 && sel <= 5) begin
      case (kind)
        KIND_BYTE, KIND_LOGICAL: data[63:8]  = '0;
        KIND_WORD:               data[63:16] = '0;
        KIND_INT, KIND_REAL:     data[63:32] = '0;
        default: ;
      endcase
    end
    send_word(kind, data, ($urandom_range(0, 7) == 0));
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  // Write the full register set while the block is idle
  task automatic load_config(input logic [63:0] in_int, input logic [63:0] out_int,
                             input logic [63:0] in_real, input logic [63:0] out_real,
                             input logic [63:0] in_dbl, input logic [63:0] out_dbl,
                             input logic [63:0] modes);
    write_reg(REG_IN_BAD_INT, in_int);
    write_reg(REG_OUT_BAD_INT, out_int);
    write_reg(REG_IN_BAD_REAL, in_real);
    write_reg(REG_OUT_BAD_REAL, out_real);
    write_reg(REG_IN_BAD_DOUBLE, in_dbl);
    write_reg(REG_OUT_BAD_DOUBLE, out_dbl);
    write_reg(REG_ORDER_MODES, modes);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Receiver: random stalls, long hold-off on request, check each accepted word
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      @(negedge clk_i);
      if (stall > 0 || hold_left > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
        while (hold_left > 0) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Main sequence
  initial begin
    logic [63:0] modes;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: swaps on, IEEE order for real and double, known bad patterns
    load_config(64'h00de_adbe_ef12_34a5, 64'h0001_0203_0405_0607, 64'hcafe_0000_0000_8000,
                64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef, 64'hfff8_0000_0000_0000,
                64'hffff_ffff_ffff_ffd7);
    send_word(KIND_BYTE,    64'h0, 1'b0);
    send_word(KIND_BYTE,    64'hffff_ffff_ffff_ff5a, 1'b0);
    send_word(KIND_BYTE,    64'ha5, 1'b1);
    send_word(KIND_LOGICAL, 64'hffff_ffff_ffff_fffe, 1'b0);
    send_word(KIND_LOGICAL, 64'h1, 1'b0);
    send_word(KIND_WORD,    64'h1234, 1'b0);
    send_word(KIND_WORD,    64'hffff_ffff_ffff_00ff, 1'b0);
    send_word(KIND_INT,     64'hdead_beef, 1'b0);
    send_word(KIND_INT,     64'hffff_ffff_0000_0001, 1'b1);
    send_word(KIND_REAL,    64'h8000, 1'b0);
    // reserved operand, both denormal exponents, first normal one, all ones
    send_word(KIND_REAL,    64'h5678_8000, 1'b0);
    send_word(KIND_REAL,    64'habcd_00ff, 1'b0);
    send_word(KIND_REAL,    64'h1357_8100, 1'b0);
    send_word(KIND_REAL,    64'h0000_0180, 1'b0);
    send_word(KIND_REAL,    64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(KIND_REAL,    64'h0, 1'b1);
    send_word(KIND_DOUBLE,  64'h0123_4567_89ab_cdef, 1'b0);
    send_word(KIND_DOUBLE,  64'hffff_ffff_ffff_8000, 1'b0);
    send_word(KIND_DOUBLE,  64'h0000_0000_0000_0080, 1'b0);
    send_word(KIND_DOUBLE,  64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(KIND_DOUBLE,  64'h0, 1'b1);
    send_word(KIND_CHAR,    64'hffff_ffff_ffff_ffff, 1'b1);
    send_word(KIND_CHAR,    64'h0, 1'b0);
    send_word(KIND_UNKNOWN, 64'h5a5a_a5a5_0f0f_f0f0, 1'b1);
    send_word(KIND_WORD,    64'habcd, 1'b1);
    wait_idle();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) begin
        load_config('0, '0, '0, '0, '0, '0, '0);
      end else if (phase == 1) begin
        load_config('1, '1, '1, '1, '1, '1, '1);
      end else begin
        modes      = {$urandom, $urandom};
        modes[5:0] = {2'(phase), 2'(phase >> 2), 2'($urandom)};
        load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    modes);
      end
      // phase 3 backs up the pipe, phase 4 runs flat out, phase 7 never stalls results
      tx_idle = (phase != 3 && phase != 4);
      rx_idle = (phase != 4 && phase != 7);
      if (phase == 3) -> hold_ev;
      repeat (PhaseWords) send_random_word();
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("Summary: %0d words sent under %0d register settings, %0d results checked.",
             words_sent, settings_used, sb.checked);
    $display("Summary: %0d bad-pattern replacements predicted, %0d mismatches.",
             sb.bad_expected, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: %0d words still outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule
